// ===== rtl/core/aps_pkg.sv =====
// Package for the allpass phase shifter cascade.
// Holds the fixed field widths, configuration register indexes and the stage control type.
// No dependencies.
package aps_pkg;

  // Pole coefficient and configuration data widths are fixed by the register map.
  localparam int unsigned COEF_WIDTH      = 16;
  localparam int unsigned COUNT_WIDTH     = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam int unsigned CFG_IDX_WIDTH   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SECTION_COUNT    = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_POLE_COEFFICIENT = 1'b1;

  // Control that travels with each sample from cell to cell.
  typedef struct packed {
    logic valid;
    logic start;
  } aps_ctl_t;

endpackage

// ===== rtl/core/aps_cell.sv =====
// One first-order allpass section of the cascade, with its own state and output register.
// Depends on aps_pkg (aps_ctl_t, COEF_WIDTH).
module aps_cell import aps_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COEF_FRAC_BITS = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic                           active_i,
  input  logic signed [COEF_WIDTH-1:0]   pole_i,
  input  aps_ctl_t                       ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] data_i,
  output aps_ctl_t                       ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0] data_o
);

  localparam int unsigned DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int unsigned PROD_W  = COEF_WIDTH + DIFF_W;
  localparam int unsigned SHIFT_W = SAMPLE_WIDTH + COEF_FRAC_BITS;
  localparam int unsigned ACC_W   = ((PROD_W > SHIFT_W) ? PROD_W : SHIFT_W) + 2;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_WIDTH-1:0] u_prev_q, u_prev_d;
  logic signed [SAMPLE_WIDTH-1:0] y_prev_q, y_prev_d;
  logic signed [SAMPLE_WIDTH-1:0] u_prev, y_prev;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        quot;
  logic                           in_range;
  logic signed [SAMPLE_WIDTH-1:0] y;
  aps_ctl_t                       ctl_q, ctl_d;
  logic signed [SAMPLE_WIDTH-1:0] data_q, data_d;

  // Block start sees a zeroed history.
  assign u_prev = ctl_i.start ? '0 : u_prev_q;
  assign y_prev = ctl_i.start ? '0 : y_prev_q;

  // r*y_prev - r*u folded into r*(y_prev - u).
  assign diff = DIFF_W'(y_prev) - DIFF_W'(data_i);
  assign prod = PROD_W'(pole_i) * PROD_W'(diff);
  assign acc  = ACC_W'(prod) + (ACC_W'(u_prev) <<< COEF_FRAC_BITS) + ROUND_BIAS;
  assign quot = acc >>> COEF_FRAC_BITS;

  // Saturate: upper bits must all match the sample sign bit.
  assign in_range = (quot[ACC_W-1:SAMPLE_WIDTH-1] == '0) ||
                    (quot[ACC_W-1:SAMPLE_WIDTH-1] == '1);

  always_comb begin
    if (in_range) begin
      y = quot[SAMPLE_WIDTH-1:0];
    end else if (quot[ACC_W-1]) begin
      y = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_comb begin
    u_prev_d = u_prev_q;
    y_prev_d = y_prev_q;
    ctl_d    = ctl_q;
    data_d   = data_q;
    if (advance_i) begin
      ctl_d  = ctl_i;
      data_d = active_i ? y : data_i;
      if (ctl_i.valid) begin
        if (active_i) begin
          u_prev_d = data_i;
          y_prev_d = y;
        end else if (ctl_i.start) begin
          u_prev_d = '0;
          y_prev_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_prev_q <= '0;
      y_prev_q <= '0;
      ctl_q    <= '0;
    end else begin
      u_prev_q <= u_prev_d;
      y_prev_q <= y_prev_d;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

// ===== rtl/core/allpass_phase_shifter_cascade.sv =====
// Top level of the allpass phase shifter cascade: configuration registers and a chain of cells.
// Depends on aps_pkg and aps_cell.
//
//   channel   direction  handshake                   payload
//   in        sink       in_valid_i / in_stall_o     sample_in_i, block_start_i
//   out       source     out_valid_o / out_stall_i   sample_out_o
//   cfg       sink       cfg_we_i                    cfg_idx_i, cfg_data_i
//
// Throughput is one sample per cycle while the output is not stalled; each cell holds one
// multiply, one add with rounding and a saturation behind its register.
// Cells past the section count forward the sample unchanged, so latency does not vary.
// Reset clears the configuration registers, all section history and all stage valids.
// A stalled result at the output freezes the whole chain; the input is stalled for
// exactly those cycles, and the next transfer is taken as soon as the result leaves.
module allpass_phase_shifter_cascade import aps_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned MAX_SECTIONS   = 3,
  parameter int unsigned COEF_FRAC_BITS = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           block_start_i,
  // sample output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_data_i
);

  logic [COUNT_WIDTH-1:0]       count_q, count_d;
  logic signed [COEF_WIDTH-1:0] pole_q, pole_d;
  logic                         advance;
  logic [MAX_SECTIONS-1:0]      active;

  // link[0] is the input side; link[k+1] is the register of cell k.
  aps_ctl_t                       link_ctl  [MAX_SECTIONS+1];
  logic signed [SAMPLE_WIDTH-1:0] link_data [MAX_SECTIONS+1];

  // Configuration writes: take whatever index matches, drop the rest.
  always_comb begin
    count_d = count_q;
    pole_d  = pole_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SECTION_COUNT:    count_d = cfg_data_i[COUNT_WIDTH-1:0];
        REG_POLE_COEFFICIENT: pole_d  = cfg_data_i[COEF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pole_q  <= '0;
    end else begin
      count_q <= count_d;
      pole_q  <= pole_d;
    end
  end

  // Advance the chain unless a finished result is held at the output.
  assign advance    = !(link_ctl[MAX_SECTIONS].valid && out_stall_i);
  assign in_stall_o = !advance;

  assign link_ctl[0].valid = in_valid_i;
  assign link_ctl[0].start = block_start_i;
  assign link_data[0]      = sample_in_i;

  for (genvar k = 0; k < MAX_SECTIONS; k++) begin : g_cell
    // Counts above the chain length clamp naturally: every cell is then active.
    assign active[k] = (int'(count_q) > k);

    aps_cell #(
      .SAMPLE_WIDTH  (SAMPLE_WIDTH),
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .active_i (active[k]),
      .pole_i   (pole_q),
      .ctl_i    (link_ctl[k]),
      .data_i   (link_data[k]),
      .ctl_o    (link_ctl[k+1]),
      .data_o   (link_data[k+1])
    );
  end

  assign out_valid_o  = link_ctl[MAX_SECTIONS].valid;
  assign sample_out_o = link_data[MAX_SECTIONS];

  // An accepted transfer always lands in the first cell.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> link_ctl[1].valid)
    else $error("accepted sample did not enter the first cell");

  // With no sections in use the first cell forwards the sample untouched.
  a_bypass_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && count_q == '0 && !cfg_we_i)
      |=> link_data[1] == $past(sample_in_i))
    else $error("bypassed sample changed in the first cell");

  // A held result freezes the first cell's register as well.
  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(link_ctl[1]) && (!link_ctl[1].valid || $stable(link_data[1]))))
    else $error("chain moved while the output was stalled");

endmodule
